[src/bkss_pkg.sv]
`default_nettype none

package bkss_pkg;

    localparam int KEY_W    = 32;
    localparam int CAP_W    = 5;
    localparam int DEPTH_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [STATUS_W-1:0] {
        ST_PUSHED = 2'd0,
        ST_FULL   = 2'd1,
        ST_FOUND  = 2'd2,
        ST_NONE   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic push;
        logic scan_start;
        logic scan_step;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic greater;
        logic at_bottom;
        logic empty;
    } stat_t;

endpackage

`default_nettype wire

[src/bkss_ctrl.sv]
`default_nettype none

module bkss_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          req_type,
    input  wire bkss_pkg::stat_t stat,
    output bkss_pkg::cmd_t     cmd,
    output logic               busy
);

    bkss_pkg::state_t state_reg;
    bkss_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bkss_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            bkss_pkg::S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (req_type)
                    begin
                        cmd.scan_start = 1'b1;
                        if (!stat.empty)
                        begin
                            state_next = bkss_pkg::S_SCAN;
                        end
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                    end
                end
            end
            bkss_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (!stat.greater)
                begin
                    state_next = bkss_pkg::S_IDLE;
                end
                else if (stat.at_bottom)
                begin
                    state_next = bkss_pkg::S_FLUSH;
                end
            end
            bkss_pkg::S_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = bkss_pkg::S_IDLE;
            end
            default:
            begin
                state_next = bkss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/bkss_dp.sv]
`default_nettype none

module bkss_dp #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bkss_pkg::cmd_t                cmd,
    output bkss_pkg::stat_t                    stat,
    input  wire logic                          cfg_we,
    input  wire logic [bkss_pkg::CAP_W-1:0]    cfg_wdata,
    input  wire logic [bkss_pkg::KEY_W-1:0]    key,
    output logic                               result_valid,
    output logic [bkss_pkg::STATUS_W-1:0]      status,
    output logic [bkss_pkg::KEY_W-1:0]         found_key,
    output logic [bkss_pkg::DEPTH_W-1:0]       depth_index,
    output logic                               last
);

    localparam int AW    = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W = (CNT_W > bkss_pkg::CAP_W) ? CNT_W : bkss_pkg::CAP_W;

    logic [bkss_pkg::KEY_W-1:0] mem [STACK_DEPTH];

    logic [bkss_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]           fill_reg;
    logic [CNT_W-1:0]           fill_next;
    logic [CNT_W-1:0]           idx_reg;
    logic [CNT_W-1:0]           idx_next;
    logic [bkss_pkg::KEY_W-1:0] key_reg;
    logic [bkss_pkg::KEY_W-1:0] rd_data_reg;
    logic                       pend_reg;
    logic                       pend_next;
    logic [bkss_pkg::KEY_W-1:0] pend_key_reg;
    logic [CNT_W-1:0]           pend_idx_reg;

    logic [CMP_W-1:0]           limit;
    logic                       can_push;
    logic                       wr_en;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;

    logic                       emit_valid;
    bkss_pkg::status_t          emit_status;
    logic [bkss_pkg::KEY_W-1:0] emit_key;
    logic [CNT_W-1:0]           emit_depth;
    logic                       emit_last;

    logic                       res_valid_reg;
    bkss_pkg::status_t          status_reg;
    logic [bkss_pkg::KEY_W-1:0] found_key_reg;
    logic [bkss_pkg::DEPTH_W-1:0] depth_reg;
    logic                       last_reg;

    assign limit = (CMP_W'(cap_reg) < CMP_W'(STACK_DEPTH)) ? CMP_W'(cap_reg)
                                                            : CMP_W'(STACK_DEPTH);
    assign can_push = CMP_W'(fill_reg) < limit;
    assign wr_en    = cmd.push && can_push;

    assign stat.greater   = rd_data_reg > key_reg;
    assign stat.at_bottom = idx_reg == CNT_W'(1);
    assign stat.empty     = fill_reg == '0;

    always_comb
    begin
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        rd_en       = 1'b0;
        rd_addr     = AW'(idx_reg - CNT_W'(2));
        emit_valid  = 1'b0;
        emit_status = bkss_pkg::ST_NONE;
        emit_key    = '0;
        emit_depth  = fill_reg;
        emit_last   = 1'b1;
        if (cmd.push)
        begin
            emit_valid = 1'b1;
            if (can_push)
            begin
                fill_next   = fill_reg + CNT_W'(1);
                emit_status = bkss_pkg::ST_PUSHED;
                emit_depth  = fill_reg + CNT_W'(1);
            end
            else
            begin
                emit_status = bkss_pkg::ST_FULL;
            end
        end
        else if (cmd.scan_start)
        begin
            pend_next = 1'b0;
            idx_next  = fill_reg;
            rd_addr   = AW'(fill_reg - CNT_W'(1));
            if (fill_reg == '0)
            begin
                emit_valid = 1'b1;
            end
            else
            begin
                rd_en = 1'b1;
            end
        end
        else if (cmd.scan_step)
        begin
            if (stat.greater)
            begin
                // hold this hit back until the next compare or the flush decides last
                emit_valid  = pend_reg;
                emit_status = bkss_pkg::ST_FOUND;
                emit_key    = pend_key_reg;
                emit_depth  = pend_idx_reg;
                emit_last   = 1'b0;
                pend_next   = 1'b1;
                idx_next    = idx_reg - CNT_W'(1);
                rd_en       = !stat.at_bottom;
            end
            else
            begin
                emit_valid = 1'b1;
                pend_next  = 1'b0;
                if (pend_reg)
                begin
                    emit_status = bkss_pkg::ST_FOUND;
                    emit_key    = pend_key_reg;
                    emit_depth  = pend_idx_reg;
                end
            end
        end
        else if (cmd.flush)
        begin
            emit_valid  = 1'b1;
            emit_status = bkss_pkg::ST_FOUND;
            emit_key    = pend_key_reg;
            emit_depth  = pend_idx_reg;
            pend_next   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_reg[AW-1:0]] <= key;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= bkss_pkg::CAP_RESET;
            fill_reg      <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            res_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.scan_start)
        begin
            key_reg <= key;
        end
        if (cmd.scan_step && stat.greater)
        begin
            pend_key_reg <= rd_data_reg;
            pend_idx_reg <= idx_reg;
        end
        status_reg    <= emit_status;
        found_key_reg <= emit_key;
        depth_reg     <= bkss_pkg::DEPTH_W'(emit_depth);
        last_reg      <= emit_last;
    end

    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign found_key    = found_key_reg;
    assign depth_index  = depth_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

[src/bounded_key_stack_with_greater_scan_unit.sv]
`default_nettype none
// Bounded stack of 32-bit packed keys with a scan for greater keys.
// Request: start with req_type and key; a transfer happens on a clock edge
// with start high and busy low. cfg_we/cfg_wdata write the capacity register
// (reset 16) and must only be used while busy is low and no result is due.
// Results: result_valid marks one cycle of status, found_key, depth_index and
// last; the receiver cannot stall, so every result shows for one cycle only.
// Push: one result the cycle after the transfer; busy stays low, so a push
// can be taken every cycle.
// Scan: n hits give n results in consecutive cycles, whether the scan stops
// at a key that is not greater or at the bottom. One stored key is read per
// cycle from the key memory. A miss on the top key gives one none-greater
// result; an empty stack gives it the cycle after the transfer. busy is low
// again in the cycle the last result shows.
// Reset empties the stack and sets capacity to 16; stored keys are not
// cleared.
module bounded_key_stack_with_greater_scan_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic [bkss_pkg::KEY_W-1:0]    key,
    input  wire logic                          cfg_we,
    input  wire logic [bkss_pkg::CAP_W-1:0]    cfg_wdata,
    output logic                               result_valid,
    output logic [bkss_pkg::STATUS_W-1:0]      status,
    output logic [bkss_pkg::KEY_W-1:0]         found_key,
    output logic [bkss_pkg::DEPTH_W-1:0]       depth_index,
    output logic                               last
);

    bkss_pkg::cmd_t  cmd;
    bkss_pkg::stat_t stat;

    bkss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    bkss_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .key          (key),
        .result_valid (result_valid),
        .status       (status),
        .found_key    (found_key),
        .depth_index  (depth_index),
        .last         (last)
    );

endmodule

`default_nettype wire

[src/bkss_checker.sv]
`default_nettype none

module bkss_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          req_type,
    input wire logic                          result_valid,
    input wire logic [bkss_pkg::STATUS_W-1:0] status,
    input wire logic [bkss_pkg::KEY_W-1:0]    found_key,
    input wire logic                          last
);

    // a push is answered the next cycle with a single push status
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !req_type |=> result_valid && last &&
        (status == bkss_pkg::ST_PUSHED || status == bkss_pkg::ST_FULL))
    else $error("push result missing");

    // results of one scan come back to back
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid && status == bkss_pkg::ST_FOUND)
    else $error("gap in scan results");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != bkss_pkg::ST_FOUND |-> last && found_key == '0)
    else $error("non-found result not final or key nonzero");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy)
    else $error("busy after final result");

endmodule

bind bounded_key_stack_with_greater_scan_unit bkss_checker u_bkss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .result_valid (result_valid),
    .status       (status),
    .found_key    (found_key),
    .last         (last)
);

`default_nettype wire
